// ===== hdl/tlpq_pkg.sv =====
// Shared types and constants of the two-level priority task queue.
package tlpq_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int unsigned CLASS_DEPTH_DEF = 32;
  localparam int unsigned ID_BITS_DEF     = 16;

  // Fixed widths of the beat fields.
  localparam int unsigned TASK_ID_W = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned REMAIN_W  = 7;

  // Command codes of an input beat.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // Take the input beat and update the rings.
    logic load_out;  // Move the finished result into the output register.
  } ctl_cmd_t;

endpackage

// ===== hdl/tlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/tlpq_ctrl.sv =====
// Controller state machine of the two-level priority task queue.
module tlpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlpq_pkg::ctl_cmd_t  ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load_out;
  logic   accept;

  // A result in flight may move on when the output register is empty or drains.
  assign load_out = (state_q == S_BUSY) && (!out_valid_q || !out_stall_i);
  assign accept   = in_valid_i && ((state_q == S_IDLE) || load_out);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (load_out && !accept) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o     = !((state_q == S_IDLE) || load_out);
  assign out_valid_o    = out_valid_q;
  assign ctl_o.accept   = accept;
  assign ctl_o.load_out = load_out;

endmodule

// ===== hdl/tlpq_dp.sv =====
// Datapath of the two-level priority task queue: rings, pointers and result registers.
module tlpq_dp #(
  parameter int unsigned CLASS_DEPTH = tlpq_pkg::CLASS_DEPTH_DEF,
  parameter int unsigned ID_BITS     = tlpq_pkg::ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tlpq_pkg::ctl_cmd_t                ctl_i,
  input  logic                              cmd_i,
  input  logic [tlpq_pkg::TASK_ID_W-1:0]    task_id_i,
  input  logic                              high_priority_i,
  output logic [tlpq_pkg::STATUS_W-1:0]     status_o,
  output logic [tlpq_pkg::TASK_ID_W-1:0]    done_id_o,
  output logic [tlpq_pkg::REMAIN_W-1:0]     remaining_o
);

  localparam int unsigned AW = $clog2(CLASS_DEPTH);
  localparam int unsigned CW = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned TW = CW + 1;

  logic [AW-1:0] hi_head_q, hi_head_d, lo_head_q, lo_head_d;
  logic [CW-1:0] hi_cnt_q, hi_cnt_d, lo_cnt_q, lo_cnt_d;

  logic          push_hi, push_lo, pop_hi, pop_lo;
  logic          is_remove;
  logic [SW-1:0] hi_sum, lo_sum;
  logic [AW-1:0] hi_wr_addr, lo_wr_addr;
  logic [ID_BITS-1:0] wr_data, hi_rd_data, lo_rd_data;
  logic [TW-1:0] total_d;
  tlpq_pkg::status_e item_status;

  // Result of the item in flight, registered at acceptance together with the ring read data.
  tlpq_pkg::status_e                work_status_q;
  logic [tlpq_pkg::REMAIN_W-1:0]    work_remain_q;
  logic                             work_from_ram_q;
  logic                             work_from_hi_q;

  tlpq_pkg::status_e                out_status_q;
  logic [tlpq_pkg::TASK_ID_W-1:0]   out_done_q;
  logic [tlpq_pkg::REMAIN_W-1:0]    out_remain_q;
  logic [tlpq_pkg::TASK_ID_W-1:0]   done_sel;

  function automatic logic [AW-1:0] next_head(input logic [AW-1:0] head);
    if (head == AW'(CLASS_DEPTH - 1)) begin
      return '0;
    end else begin
      return head + AW'(1);
    end
  endfunction

  assign is_remove = (cmd_i == tlpq_pkg::CMD_REMOVE);

  assign push_hi = !is_remove && high_priority_i && (hi_cnt_q != CW'(CLASS_DEPTH));
  assign push_lo = !is_remove && !high_priority_i && (lo_cnt_q != CW'(CLASS_DEPTH));
  assign pop_hi  = is_remove && (hi_cnt_q != '0);
  assign pop_lo  = is_remove && (hi_cnt_q == '0) && (lo_cnt_q != '0);

  // Tail position is head plus count, folded back once into the ring.
  assign hi_sum     = SW'(hi_head_q) + SW'(hi_cnt_q);
  assign lo_sum     = SW'(lo_head_q) + SW'(lo_cnt_q);
  assign hi_wr_addr = AW'((hi_sum >= SW'(CLASS_DEPTH)) ? hi_sum - SW'(CLASS_DEPTH) : hi_sum);
  assign lo_wr_addr = AW'((lo_sum >= SW'(CLASS_DEPTH)) ? lo_sum - SW'(CLASS_DEPTH) : lo_sum);
  assign wr_data    = ID_BITS'(task_id_i);

  always_comb begin
    hi_head_d = hi_head_q;
    lo_head_d = lo_head_q;
    hi_cnt_d  = hi_cnt_q;
    lo_cnt_d  = lo_cnt_q;
    if (push_hi) begin
      hi_cnt_d = hi_cnt_q + CW'(1);
    end
    if (push_lo) begin
      lo_cnt_d = lo_cnt_q + CW'(1);
    end
    if (pop_hi) begin
      hi_cnt_d  = hi_cnt_q - CW'(1);
      hi_head_d = next_head(hi_head_q);
    end
    if (pop_lo) begin
      lo_cnt_d  = lo_cnt_q - CW'(1);
      lo_head_d = next_head(lo_head_q);
    end
  end

  always_comb begin
    item_status = tlpq_pkg::ST_OK;
    if (is_remove) begin
      if (!pop_hi && !pop_lo) begin
        item_status = tlpq_pkg::ST_EMPTY;
      end
    end else if (!push_hi && !push_lo) begin
      item_status = tlpq_pkg::ST_FULL;
    end
  end

  assign total_d = TW'(hi_cnt_d) + TW'(lo_cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_head_q <= '0;
      lo_head_q <= '0;
      hi_cnt_q  <= '0;
      lo_cnt_q  <= '0;
    end else if (ctl_i.accept) begin
      hi_head_q <= hi_head_d;
      lo_head_q <= lo_head_d;
      hi_cnt_q  <= hi_cnt_d;
      lo_cnt_q  <= lo_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      work_status_q   <= item_status;
      work_remain_q   <= tlpq_pkg::REMAIN_W'(total_d);
      work_from_ram_q <= pop_hi || pop_lo;
      work_from_hi_q  <= pop_hi;
    end
  end

  tlpq_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(CLASS_DEPTH)
  ) u_hi_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ctl_i.accept && push_hi),
    .wr_addr_i (hi_wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (ctl_i.accept && pop_hi),
    .rd_addr_i (hi_head_q),
    .rd_data_o (hi_rd_data)
  );

  tlpq_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(CLASS_DEPTH)
  ) u_lo_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ctl_i.accept && push_lo),
    .wr_addr_i (lo_wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (ctl_i.accept && pop_lo),
    .rd_addr_i (lo_head_q),
    .rd_data_o (lo_rd_data)
  );

  always_comb begin
    done_sel = '0;
    if (work_from_ram_q) begin
      done_sel = work_from_hi_q ? tlpq_pkg::TASK_ID_W'(hi_rd_data)
                                : tlpq_pkg::TASK_ID_W'(lo_rd_data);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_status_q <= work_status_q;
      out_done_q   <= done_sel;
      out_remain_q <= work_remain_q;
    end
  end

  assign status_o    = out_status_q;
  assign done_id_o   = out_done_q;
  assign remaining_o = out_remain_q;

endmodule

// ===== hdl/two_level_priority_task_queue_unit.sv =====
// Top level of the two-level priority task queue: controller plus datapath.
//
//   channel  direction  handshake                 fields
//   in       input      in_valid_i / in_stall_o   cmd_i, task_id_i, high_priority_i
//   out      output     out_valid_o / out_stall_i status_o, done_id_o, remaining_o
//
// Every accepted input beat gives exactly one output beat, in order. Its result
// is first registered beside the task number of a remove, which comes out of the
// registered read port of the ring RAM, and then moves into the output register
// when that register is empty or drains.
// A new beat is taken in the same cycle as the previous result moves out, so the
// queue sustains one beat per cycle while the output side keeps draining.
// Reset clears both ring pointers and counts at once; ring contents need no
// clearing, since an entry is only read after it has been written.
// When the output is stalled with a result waiting, one more beat is held in
// flight and then in_stall_o rises until the output register frees.
module two_level_priority_task_queue_unit #(
  parameter int unsigned CLASS_DEPTH = tlpq_pkg::CLASS_DEPTH_DEF,
  parameter int unsigned ID_BITS     = tlpq_pkg::ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [tlpq_pkg::TASK_ID_W-1:0]    task_id_i,
  input  logic                              high_priority_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tlpq_pkg::STATUS_W-1:0]     status_o,
  output logic [tlpq_pkg::TASK_ID_W-1:0]    done_id_o,
  output logic [tlpq_pkg::REMAIN_W-1:0]     remaining_o
);

  // Command bundle from the controller: take a beat, and release a result.
  tlpq_pkg::ctl_cmd_t ctl;

  // The controller owns the handshakes and the output valid flag.
  tlpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  // The datapath keeps the two rings with their heads and counts, and forms
  // the status, removed task number and remaining count of each beat.
  tlpq_dp #(
    .CLASS_DEPTH(CLASS_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .cmd_i           (cmd_i),
    .task_id_i       (task_id_i),
    .high_priority_i (high_priority_i),
    .status_o        (status_o),
    .done_id_o       (done_id_o),
    .remaining_o     (remaining_o)
  );

endmodule
